>>> sv/sba_pkg.sv
package sba_pkg;

    localparam int MAP_BYTES_DEF = 2048;
    localparam int RES_W = 15;
    localparam logic [RES_W-1:0] RESERVED_RESET = 15'd131;

    localparam int REQ_W = 2;
    localparam int IDX_W = 11;
    localparam int BYTE_W = 8;
    localparam int SECTOR_W = 14;

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC  = 2'd0,
        REQ_FORMAT = 2'd1,
        REQ_LOAD   = 2'd2,
        REQ_READ   = 2'd3
    } req_t;

    localparam logic [BYTE_W-1:0] BYTE_FULL = 8'hFF;

endpackage

>>> sv/sba_ram.sv
module sba_ram import sba_pkg::*;
#(
    parameter int DEPTH = MAP_BYTES_DEF,
    parameter int AW = 11
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [BYTE_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/sector_bitmap_allocator_unit.sv
// Allocate: scans one map byte per cycle.
// Format: writes one map byte per cycle.
// Load writes the map byte on accept; Read uses a synchronous map read.
// One request at a time; a finished result waits in the output register.
// Reset: async active low; afterwards the map is cleared by a pass over every byte
// during which no request is accepted.
module sector_bitmap_allocator_unit import sba_pkg::*;
#(
    parameter int MAP_BYTES = MAP_BYTES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [RES_W-1:0]    cfg_wdata,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [IDX_W-1:0]    byte_index,
    input  logic [BYTE_W-1:0]   byte_value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [SECTOR_W-1:0] sector,
    output logic                full_res,
    output logic [BYTE_W-1:0]   read_byte
);

    localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int CNT_W = AW + 1;
    localparam int TOTAL = MAP_BYTES * 8;
    localparam int NW = $clog2(TOTAL + 1);
    localparam int FBW = NW - 3;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(MAP_BYTES - 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(MAP_BYTES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_SCAN,
        ST_READ,
        ST_DELIVER
    } state_t;

    state_t              state_reg, state_next;
    logic [RES_W-1:0]    reserved_reg;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                chk_valid_reg, chk_valid_next;
    logic [AW-1:0]       chk_addr_reg, chk_addr_next;
    logic [FBW-1:0]      fmt_full_reg, fmt_full_next;
    logic [2:0]          fmt_rest_reg, fmt_rest_next;
    logic                fmt_reply_reg, fmt_reply_next;
    logic                rd_ok_reg, rd_ok_next;
    logic [SECTOR_W-1:0] res_sector_reg, res_sector_next;
    logic                res_full_reg, res_full_next;
    logic [BYTE_W-1:0]   res_byte_reg, res_byte_next;
    logic                out_valid_reg, out_valid_next;
    logic [SECTOR_W-1:0] sector_reg, sector_next;
    logic                full_reg, full_next;
    logic [BYTE_W-1:0]   read_byte_reg, read_byte_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [BYTE_W-1:0]   ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [BYTE_W-1:0]   ram_rdata;

    logic                accept;
    logic                issue;
    logic                found;
    logic [2:0]          free_bit;
    logic [31:0]         n_ext;
    logic                idx_ok;
    logic [BYTE_W-1:0]   sweep_byte;
    logic [AW+2:0]       sec_full;

    sba_ram #(
        .DEPTH (MAP_BYTES),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign accept = in_valid && !in_stall;
    assign issue = (cnt_reg < DEPTH_C);
    assign found = chk_valid_reg && (ram_rdata != BYTE_FULL);
    assign idx_ok = (17'(byte_index) < 17'(MAP_BYTES));
    assign n_ext = (32'(reserved_reg) > 32'(TOTAL)) ? 32'(TOTAL) : 32'(reserved_reg);
    assign sec_full = {chk_addr_reg, free_bit};

    always_comb
    begin
        free_bit = 3'd0;
        for (int k = 7; k >= 0; k--)
        begin
            if (!ram_rdata[k])
            begin
                free_bit = 3'(k);
            end
        end
    end

    always_comb
    begin
        if (32'(cnt_reg) < 32'(fmt_full_reg))
        begin
            sweep_byte = BYTE_FULL;
        end
        else if (32'(cnt_reg) == 32'(fmt_full_reg))
        begin
            sweep_byte = 8'((9'd1 << fmt_rest_reg) - 9'd1);
        end
        else
        begin
            sweep_byte = '0;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        chk_valid_next  = chk_valid_reg;
        chk_addr_next   = chk_addr_reg;
        fmt_full_next   = fmt_full_reg;
        fmt_rest_next   = fmt_rest_reg;
        fmt_reply_next  = fmt_reply_reg;
        rd_ok_next      = rd_ok_reg;
        res_sector_next = res_sector_reg;
        res_full_next   = res_full_reg;
        res_byte_next   = res_byte_reg;
        out_valid_next  = out_valid_reg && out_stall;
        sector_next     = sector_reg;
        full_next       = full_reg;
        read_byte_next  = read_byte_reg;
        ram_we          = 1'b0;
        ram_waddr       = cnt_reg[AW-1:0];
        ram_wdata       = sweep_byte;
        ram_raddr       = cnt_reg[AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = AW'(byte_index);
                if (accept)
                begin
                    res_sector_next = '0;
                    res_full_next   = 1'b0;
                    res_byte_next   = '0;
                    unique case (req_t'(req_type))
                        REQ_ALLOC:
                        begin
                            cnt_next       = '0;
                            chk_valid_next = 1'b0;
                            state_next     = ST_SCAN;
                        end
                        REQ_FORMAT:
                        begin
                            cnt_next       = '0;
                            fmt_full_next  = FBW'(n_ext >> 3);
                            fmt_rest_next  = n_ext[2:0];
                            fmt_reply_next = 1'b1;
                            state_next     = ST_SWEEP;
                        end
                        REQ_LOAD:
                        begin
                            ram_we     = idx_ok;
                            ram_waddr  = AW'(byte_index);
                            ram_wdata  = byte_value;
                            state_next = ST_DELIVER;
                        end
                        REQ_READ:
                        begin
                            rd_ok_next = idx_ok;
                            state_next = ST_READ;
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                ram_we   = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST)
                begin
                    state_next = fmt_reply_reg ? ST_DELIVER : ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                chk_valid_next = issue;
                chk_addr_next  = cnt_reg[AW-1:0];
                if (issue)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (found)
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = chk_addr_reg;
                    ram_wdata       = ram_rdata | (8'd1 << free_bit);
                    res_sector_next = SECTOR_W'(sec_full);
                    state_next      = ST_DELIVER;
                end
                else if (!issue)
                begin
                    res_full_next = 1'b1;
                    state_next    = ST_DELIVER;
                end
            end
            ST_READ:
            begin
                res_byte_next = rd_ok_reg ? ram_rdata : '0;
                state_next    = ST_DELIVER;
            end
            ST_DELIVER:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    sector_next    = res_sector_reg;
                    full_next      = res_full_reg;
                    read_byte_next = res_byte_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            cnt_reg        <= '0;
            chk_valid_reg  <= 1'b0;
            chk_addr_reg   <= '0;
            fmt_full_reg   <= '0;
            fmt_rest_reg   <= '0;
            fmt_reply_reg  <= 1'b0;
            rd_ok_reg      <= 1'b0;
            res_sector_reg <= '0;
            res_full_reg   <= 1'b0;
            res_byte_reg   <= '0;
            out_valid_reg  <= 1'b0;
            sector_reg     <= '0;
            full_reg       <= 1'b0;
            read_byte_reg  <= '0;
            reserved_reg   <= RESERVED_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            chk_valid_reg  <= chk_valid_next;
            chk_addr_reg   <= chk_addr_next;
            fmt_full_reg   <= fmt_full_next;
            fmt_rest_reg   <= fmt_rest_next;
            fmt_reply_reg  <= fmt_reply_next;
            rd_ok_reg      <= rd_ok_next;
            res_sector_reg <= res_sector_next;
            res_full_reg   <= res_full_next;
            res_byte_reg   <= res_byte_next;
            out_valid_reg  <= out_valid_next;
            sector_reg     <= sector_next;
            full_reg       <= full_next;
            read_byte_reg  <= read_byte_next;
            if (cfg_we)
            begin
                reserved_reg <= cfg_wdata;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign sector    = sector_reg;
    assign full_res  = full_reg;
    assign read_byte = read_byte_reg;

    a_full_no_sector: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && full_res |-> sector == '0)
        else $error("full result carries a sector number");

    a_read_only_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_byte != '0 |-> sector == '0 && !full_res)
        else $error("read result carries allocate fields");

    a_scan_write_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN && ram_we |-> chk_valid_reg && ram_rdata != BYTE_FULL)
        else $error("scan writes the map without a free bit");

    a_deliver_after_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DELIVER && out_valid_reg && out_stall |=> state_reg == ST_DELIVER)
        else $error("result left while output still held");

endmodule

>>> verif/tb_top.sv
module tb_top;
    import sba_pkg::*;

    localparam int RAND_ITEMS = 255;

    typedef struct {
        logic [SECTOR_W-1:0] sector;
        logic                full;
        logic [BYTE_W-1:0]   rd;
    } sba_answer_s;

    typedef struct {
        bit                  cfg_row;
        logic [RES_W-1:0]    reserve;
        req_t                req;
        logic [IDX_W-1:0]    idx;
        logic [BYTE_W-1:0]   val;
        bit                  typed;
        logic [SECTOR_W-1:0] sector;
        logic                full;
        logic [BYTE_W-1:0]   rd;
    } script_row_s;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [RES_W-1:0]    cfg_wdata;
    logic                in_valid;
    logic                in_stall;
    logic [REQ_W-1:0]    req_type;
    logic [IDX_W-1:0]    byte_index;
    logic [BYTE_W-1:0]   byte_value;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [SECTOR_W-1:0] sector;
    logic                full_res;
    logic [BYTE_W-1:0]   read_byte;

    logic [BYTE_W-1:0]   usage_map_m [MAP_BYTES_DEF] = '{default: '0};
    logic [RES_W-1:0]    reserve_m = RESERVED_RESET;
    sba_answer_s         due_answers [$];
    int                  fail_count = 0;
    int                  items_sent = 0;
    int                  gap_pct = 0;
    int                  stall_pct = 0;

    logic [RES_W-1:0] reserve_marks [7] = '{15'd0, 15'd1, 15'd8, 15'd131, 15'd16383,
                                            15'd16384, 15'd32767};

    script_row_s script_rows [30] = '{
        '{1'b0, 15'd0,     REQ_READ,   11'd0,     8'h00, 1'b1, 14'd0,     1'b0, 8'h00},
        '{1'b0, 15'd0,     REQ_READ,   11'd2047,  8'h00, 1'b1, 14'd0,     1'b0, 8'h00},
        '{1'b0, 15'd0,     REQ_ALLOC,  11'd0,     8'h00, 1'b1, 14'd0,     1'b0, 8'h00},
        '{1'b0, 15'd0,     REQ_ALLOC,  11'd0,     8'h00, 1'b1, 14'd1,     1'b0, 8'h00},
        '{1'b0, 15'd0,     REQ_LOAD,   11'd0,     8'hFF, 1'b1, 14'd0,     1'b0, 8'h00},
        '{1'b0, 15'd0,     REQ_ALLOC,  11'd0,     8'h00, 1'b1, 14'd8,     1'b0, 8'h00},
        '{1'b0, 15'd0,     REQ_LOAD,   11'd2047,  8'hAA, 1'b1, 14'd0,     1'b0, 8'h00},
        '{1'b0, 15'd0,     REQ_READ,   11'd2047,  8'h00, 1'b1, 14'd0,     1'b0, 8'hAA},
        '{1'b0, 15'd0,     REQ_LOAD,   11'd1,     8'h7F, 1'b1, 14'd0,     1'b0, 8'h00},
        '{1'b0, 15'd0,     REQ_ALLOC,  11'd0,     8'h00, 1'b1, 14'd15,    1'b0, 8'h00},
        '{1'b0, 15'd0,     REQ_FORMAT, 11'd0,     8'h00, 1'b1, 14'd0,     1'b0, 8'h00},
        '{1'b0, 15'd0,     REQ_READ,   11'd16,    8'h00, 1'b1, 14'd0,     1'b0, 8'h07},
        '{1'b0, 15'd0,     REQ_ALLOC,  11'd0,     8'h00, 1'b1, 14'd131,   1'b0, 8'h00},
        '{1'b1, 15'd0,     REQ_ALLOC,  11'd0,     8'h00, 1'b0, 14'd0,     1'b0, 8'h00},
        '{1'b0, 15'd0,     REQ_FORMAT, 11'd0,     8'h00, 1'b1, 14'd0,     1'b0, 8'h00},
        '{1'b0, 15'd0,     REQ_ALLOC,  11'd0,     8'h00, 1'b1, 14'd0,     1'b0, 8'h00},
        '{1'b1, 15'd32767, REQ_ALLOC,  11'd0,     8'h00, 1'b0, 14'd0,     1'b0, 8'h00},
        '{1'b0, 15'd0,     REQ_FORMAT, 11'd0,     8'h00, 1'b1, 14'd0,     1'b0, 8'h00},
        '{1'b0, 15'd0,     REQ_ALLOC,  11'd0,     8'h00, 1'b1, 14'd0,     1'b1, 8'h00},
        '{1'b0, 15'd0,     REQ_LOAD,   11'd2047,  8'h7F, 1'b1, 14'd0,     1'b0, 8'h00},
        '{1'b0, 15'd0,     REQ_ALLOC,  11'd0,     8'h00, 1'b1, 14'd16383, 1'b0, 8'h00},
        '{1'b0, 15'd0,     REQ_ALLOC,  11'd0,     8'h00, 1'b1, 14'd0,     1'b1, 8'h00},
        '{1'b1, 15'd16384, REQ_ALLOC,  11'd0,     8'h00, 1'b0, 14'd0,     1'b0, 8'h00},
        '{1'b0, 15'd0,     REQ_FORMAT, 11'd0,     8'h00, 1'b1, 14'd0,     1'b0, 8'h00},
        '{1'b0, 15'd0,     REQ_ALLOC,  11'd0,     8'h00, 1'b1, 14'd0,     1'b1, 8'h00},
        '{1'b1, 15'd8,     REQ_ALLOC,  11'd0,     8'h00, 1'b0, 14'd0,     1'b0, 8'h00},
        '{1'b0, 15'd0,     REQ_FORMAT, 11'd0,     8'h00, 1'b1, 14'd0,     1'b0, 8'h00},
        '{1'b0, 15'd0,     REQ_ALLOC,  11'd0,     8'h00, 1'b1, 14'd8,     1'b0, 8'h00},
        '{1'b0, 15'd0,     REQ_READ,   11'h555,   8'h00, 1'b0, 14'd0,     1'b0, 8'h00},
        '{1'b0, 15'd0,     REQ_LOAD,   11'h2AA,   8'h55, 1'b0, 14'd0,     1'b0, 8'h00}
    };

    sector_bitmap_allocator_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .byte_index (byte_index),
        .byte_value (byte_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sector     (sector),
        .full_res   (full_res),
        .read_byte  (read_byte)
    );

    always #2 clk = ~clk;

    always @(negedge clk)
        out_stall <= ($urandom_range(99, 0) < stall_pct);

    function automatic sba_answer_s serve_request(input req_t rq,
                                                  input logic [IDX_W-1:0] ix,
                                                  input logic [BYTE_W-1:0] bv);
        sba_answer_s ans;
        int          span;
        bit          found;
        ans.sector = '0;
        ans.full   = 1'b0;
        ans.rd     = '0;
        found      = 1'b0;
        case (rq)
            REQ_ALLOC:
            begin
                for (int b = 0; b < MAP_BYTES_DEF && !found; b++)
                    for (int j = 0; j < 8 && !found; j++)
                        if (!usage_map_m[b][j])
                        begin
                            usage_map_m[b][j] = 1'b1;
                            ans.sector = SECTOR_W'(b * 8 + j);
                            found = 1'b1;
                        end
                ans.full = !found;
            end
            REQ_FORMAT:
            begin
                span = int'(reserve_m);
                if (span > MAP_BYTES_DEF * 8)
                    span = MAP_BYTES_DEF * 8;
                for (int b = 0; b < MAP_BYTES_DEF; b++)
                    if (b < span / 8)
                        usage_map_m[b] = BYTE_FULL;
                    else if (b == span / 8)
                        usage_map_m[b] = BYTE_W'((1 << (span % 8)) - 1);
                    else
                        usage_map_m[b] = '0;
            end
            REQ_LOAD:
                usage_map_m[ix] = bv;
            default:
                ans.rd = usage_map_m[ix];
        endcase
        return ans;
    endfunction

    // bias toward the allocation frontier so loads punch holes where allocates look
    function automatic logic [IDX_W-1:0] pick_index();
        int frontier;
        frontier = int'(reserve_m) / 8 + int'($urandom_range(2, 0)) - 1;
        if (frontier > MAP_BYTES_DEF - 1)
            frontier = MAP_BYTES_DEF - 1;
        if (frontier < 0)
            frontier = 0;
        if ($urandom_range(99, 0) < 35)
            return IDX_W'($urandom);
        return IDX_W'(frontier);
    endfunction

    task automatic issue_request(input req_t rq, input logic [IDX_W-1:0] ix,
                                 input logic [BYTE_W-1:0] bv);
        while ($urandom_range(99, 0) < gap_pct)
        begin
            in_valid   <= 1'b0;
            req_type   <= REQ_W'($urandom);
            byte_index <= IDX_W'($urandom);
            byte_value <= BYTE_W'($urandom);
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= rq;
        byte_index <= ix;
        byte_value <= bv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        due_answers.push_back(serve_request(rq, ix, bv));
        items_sent++;
    endtask

    // drain every outstanding transfer, then write the register
    task automatic set_reserve(input logic [RES_W-1:0] v);
        in_valid <= 1'b0;
        while (due_answers.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        reserve_m = v;
    endtask

    task automatic note_mismatch(input string what, input int want, input int got);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endtask

    always @(posedge clk)
    begin : answer_check
        sba_answer_s want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_answers.size() == 0)
                note_mismatch("unexpected transfer, sector", 0, int'(sector));
            else
            begin
                want = due_answers.pop_front();
                if (sector !== want.sector)
                    note_mismatch("sector", int'(want.sector), int'(sector));
                if (full_res !== want.full)
                    note_mismatch("full_res", int'(want.full), int'(full_res));
                if (read_byte !== want.rd)
                    note_mismatch("read_byte", int'(want.rd), int'(read_byte));
            end
        end
    end

    initial
    begin
        #12_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        int               rand_base;
        int               phase;
        int               pick;
        int               kind;
        logic [RES_W-1:0] rv;
        logic [BYTE_W-1:0] bv;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        in_valid   = 1'b0;
        req_type   = REQ_ALLOC;
        byte_index = '0;
        byte_value = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (script_rows[r])
        begin
            if (script_rows[r].cfg_row)
                set_reserve(script_rows[r].reserve);
            else
            begin
                issue_request(script_rows[r].req, script_rows[r].idx, script_rows[r].val);
                if (script_rows[r].typed)
                    due_answers[due_answers.size() - 1] = '{script_rows[r].sector,
                                                            script_rows[r].full,
                                                            script_rows[r].rd};
            end
        end

        rand_base = items_sent;
        while (items_sent - rand_base < RAND_ITEMS)
        begin
            phase = (items_sent - rand_base) * 4 / RAND_ITEMS;
            case (phase)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct   = 54;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct   = 0;
                    stall_pct = 54;
                end
                default:
                begin
                    gap_pct   = 27;
                    stall_pct = 27;
                end
            endcase
            pick = $urandom_range(99, 0);
            if (pick < 10)
                rv = reserve_marks[$urandom_range(6, 0)];
            else if (pick < 25)
                rv = RES_W'($urandom);
            else
                rv = RES_W'($urandom_range(1023, 0));
            set_reserve(rv);
            issue_request(REQ_FORMAT, IDX_W'($urandom), BYTE_W'($urandom));
            repeat ($urandom_range(20, 6))
            begin
                kind = $urandom_range(99, 0);
                if (kind < 55)
                    issue_request(REQ_ALLOC, IDX_W'($urandom), BYTE_W'($urandom));
                else if (kind < 75)
                begin
                    bv = ($urandom_range(3, 0) == 0) ? BYTE_FULL : BYTE_W'($urandom);
                    issue_request(REQ_LOAD, pick_index(), bv);
                end
                else if (kind < 92)
                    issue_request(REQ_READ, pick_index(), BYTE_W'($urandom));
                else
                    issue_request(req_t'(REQ_W'($urandom)), IDX_W'($urandom),
                                  BYTE_W'($urandom));
            end
        end

        in_valid <= 1'b0;
        while (due_answers.size() != 0)
            @(negedge clk);
        repeat (2100) @(negedge clk);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

>>> sim.f
sv/sba_pkg.sv
sv/sba_ram.sv
sv/sector_bitmap_allocator_unit.sv
verif/tb_top.sv
